FILE: design/bfw_pkg.sv
// Shared constants and types for the bilateral filter window block.
`timescale 1ns / 1ps
package bfw_pkg;

	// Sizing of the image, window and weights
	localparam int MAX_WIDTH   = 1024;
	localparam int MAX_HEIGHT  = 1024;
	localparam int MAX_RADIUS  = 3;
	localparam int WEIGHT_BITS = 16;

	// Fixed widths of the interface fields
	localparam int DIM_W  = 11;
	localparam int PIX_W  = 8;
	localparam int CMD_W  = 2;
	localparam int TIDX_W = 8;
	localparam int TW_W   = 16;
	localparam int CFG_AW = 3;
	localparam int CFG_DW = 11;

	// Line store geometry
	localparam int LS_ROWS  = 2 * MAX_RADIUS + 2;
	localparam int SLOT_W   = $clog2(LS_ROWS);
	localparam int COL_W    = $clog2(MAX_WIDTH);
	localparam int ROW_W    = $clog2(MAX_HEIGHT);
	localparam int LS_DEPTH = LS_ROWS * MAX_WIDTH;
	localparam int ADDR_W   = $clog2(LS_DEPTH);

	// Window geometry
	localparam int RAD_W    = $clog2(MAX_RADIUS + 1);
	localparam int D_W      = RAD_W + 1;
	localparam int SP_DEPTH = 2 * MAX_RADIUS * MAX_RADIUS + 1;
	localparam int SP_W     = $clog2(SP_DEPTH);
	localparam int NWIN     = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
	localparam int RG_DEPTH = 256;

	// Signed coordinate width, roomy enough for any row, column or dimension
	localparam int CW_A = (ROW_W > COL_W) ? ROW_W : COL_W;
	localparam int Y_W  = ((CW_A > DIM_W) ? CW_A : DIM_W) + 2;
	localparam int SL_W = SLOT_W + RAD_W + 2;

	// Arithmetic widths
	localparam int W_W     = 2 * WEIGHT_BITS;
	localparam int PROD_W  = W_W + PIX_W;
	localparam int NORM_W  = W_W + $clog2(NWIN);
	localparam int SUM_W   = NORM_W + PIX_W;
	localparam int QBITS   = PIX_W + 1;

	// Register indexes
	localparam logic [CFG_AW-1:0] REG_WIDTH  = 3'd0;
	localparam logic [CFG_AW-1:0] REG_HEIGHT = 3'd1;
	localparam logic [CFG_AW-1:0] REG_RADIUS = 3'd2;
	localparam logic [CFG_AW-1:0] REG_BMODE  = 3'd3;
	localparam logic [CFG_AW-1:0] REG_BVALUE = 3'd4;

	// Input commands
	localparam logic [CMD_W-1:0] CMD_PIXEL = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RANGE = 2'd2;
	localparam logic [CMD_W-1:0] CMD_SPAT  = 2'd3;

	// Work carried from one divider cell to the next
	typedef struct packed {
		logic [SUM_W-1:0] rem;
		logic [SUM_W-1:0] dvs;
		logic [QBITS-1:0] quo;
		logic [PIX_W-1:0] centre;
		logic             zero;
	} div_t;

endpackage

FILE: design/bfw_div_cell.sv
// One restoring divider cell: settles one quotient bit and hands on.
`timescale 1ns / 1ps
module bfw_div_cell (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_v,
	input  bfw_pkg::div_t in_d,
	output logic        out_v,
	output bfw_pkg::div_t out_d
);
	import bfw_pkg::*;

	logic ge;

	assign ge = (in_d.rem >= in_d.dvs);

	// Track occupancy of the cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v <= 1'b0;
		end else begin
			out_v <= in_v;
		end
	end

	// Subtract when it fits, shift quotient and divisor
	always_ff @(posedge clk) begin
		out_d.rem    <= ge ? (in_d.rem - in_d.dvs) : in_d.rem;
		out_d.dvs    <= in_d.dvs >> 1;
		out_d.quo    <= {in_d.quo[QBITS-2:0], ge};
		out_d.centre <= in_d.centre;
		out_d.zero   <= in_d.zero;
	end

endmodule

FILE: design/bfw_div_chain.sv
// Row of divider cells producing a 9-bit quotient.
`timescale 1ns / 1ps
module bfw_div_chain (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  bfw_pkg::div_t start_d,
	output logic          done,
	output bfw_pkg::div_t done_d
);
	import bfw_pkg::*;

	logic v_c [QBITS+1];
	div_t d_c [QBITS+1];

	assign v_c[0] = start;
	assign d_c[0] = start_d;

	// Chain the cells, one quotient bit each
	for (genvar i = 0; i < QBITS; i++) begin : g_cell
		bfw_div_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.in_v  (v_c[i]),
			.in_d  (d_c[i]),
			.out_v (v_c[i+1]),
			.out_d (d_c[i+1])
		);
	end

	assign done   = v_c[QBITS];
	assign done_d = d_c[QBITS];

endmodule

FILE: design/bilateral_filter_window.sv
// Top level of the streaming bilateral filter over a square window.
`timescale 1ns / 1ps
// Streaming bilateral filter for 8-bit raster images. A table load leaves the
// block idle. A pixel or flush beat that yields no result goes through the
// check state back to idle; one that yields a result sweeps the centre tap
// and then the window, one tap per cycle through the single read port of the
// line store, and the quotient then passes a nine-cell divider chain. The
// next beat is taken while a finished result still waits on the output side.
// Line store and weight tables power up undefined; load every range and
// spatial weight that the chosen radius touches before sending pixels. A
// write to any of the five registers restarts the frame.
module bilateral_filter_window (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [bfw_pkg::CMD_W-1:0]   cmd,
	input  logic [bfw_pkg::PIX_W-1:0]   pixel,
	input  logic [bfw_pkg::TIDX_W-1:0]  table_index,
	input  logic [bfw_pkg::TW_W-1:0]    table_weight,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [bfw_pkg::PIX_W-1:0]   filtered,
	output logic                        last,
	input  logic                        cfg_we,
	input  logic [bfw_pkg::CFG_AW-1:0]  cfg_addr,
	input  logic [bfw_pkg::CFG_DW-1:0]  cfg_wdata
);
	import bfw_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_CHECK = 6'b000010,
		ST_SWEEP = 6'b000100,
		ST_DRAIN = 6'b001000,
		ST_DIV   = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t state_q;

	// Configuration registers
	logic [DIM_W-1:0] width_q, height_q;
	logic [RAD_W-1:0] radius_q;
	logic             bmode_q;
	logic [PIX_W-1:0] bvalue_q;

	logic [DIM_W-1:0] w_eff, h_eff;
	logic [RAD_W-1:0] r_eff;

	// Frame position
	logic [COL_W-1:0]  in_col_q, out_col_q;
	logic [ROW_W-1:0]  in_row_q, out_row_q;
	logic [SLOT_W-1:0] in_slot_q, out_slot_q;
	logic              frame_in_q;

	// Storage
	logic [PIX_W-1:0]       line_mem [LS_DEPTH];
	logic [WEIGHT_BITS-1:0] range_mem [RG_DEPTH];
	logic [WEIGHT_BITS-1:0] spatial_q [SP_DEPTH];
	logic [PIX_W-1:0]       ls_rdata;
	logic [WEIGHT_BITS-1:0] rg_rdata;

	// Sweep control
	logic                 first_q;
	logic signed [D_W-1:0] dy_q, dx_q;

	// Pipeline
	logic                  v_s1, ctr_s1, brd_s1;
	logic [SP_W-1:0]       sidx_s1;
	logic                  v_s2;
	logic [PIX_W-1:0]      p_s2;
	logic [WEIGHT_BITS-1:0] s_s2;
	logic                  v_s3;
	logic [PIX_W-1:0]      p_s3;
	logic [W_W-1:0]        w_s3;
	logic                  v_s4;
	logic [PROD_W-1:0]     prod_s4;
	logic [W_W-1:0]        wn_s4;
	logic [PIX_W-1:0]      centre_q;
	logic [SUM_W-1:0]      sum_q;
	logic [NORM_W-1:0]     norm_q;

	// Divider
	logic  div_start, div_done;
	div_t  div_in, div_out;
	logic [PIX_W-1:0] res_q;

	logic accept_in, out_take, frame_last, ready_now;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept_in = in_valid && !in_stall;
	assign out_take  = out_valid && !out_stall;

	// Clip configuration to what the hardware holds
	always_comb begin
		if (width_q == '0) w_eff = DIM_W'(1);
		else if (DIM_W'(MAX_WIDTH) < width_q) w_eff = DIM_W'(MAX_WIDTH);
		else w_eff = width_q;
		if (height_q == '0) h_eff = DIM_W'(1);
		else if (DIM_W'(MAX_HEIGHT) < height_q) h_eff = DIM_W'(MAX_HEIGHT);
		else h_eff = height_q;
		r_eff = (radius_q > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius_q;
	end

	// Decide whether the next output's window has arrived
	logic [Y_W-1:0] nr, nc, hm1, wm1;
	always_comb begin
		hm1 = Y_W'(h_eff) - Y_W'(1);
		wm1 = Y_W'(w_eff) - Y_W'(1);
		nr  = Y_W'(out_row_q) + Y_W'(r_eff);
		nc  = Y_W'(out_col_q) + Y_W'(r_eff);
		if (nr > hm1) nr = hm1;
		if (nc > wm1) nc = wm1;
		ready_now = frame_in_q || (Y_W'(in_row_q) > nr)
			|| ((Y_W'(in_row_q) == nr) && (Y_W'(in_col_q) > nc));
		frame_last = (Y_W'(out_row_q) == hm1) && (Y_W'(out_col_q) == wm1);
	end

	// Window tap address
	logic signed [D_W-1:0]  ody, odx, dyc;
	logic signed [Y_W-1:0]  yv, xv, yc, xc, hs, ws;
	logic signed [SL_W-1:0] slv;
	logic [SLOT_W-1:0]      rd_slot;
	logic [ADDR_W-1:0]      rd_addr, wr_addr;
	logic                   outside;
	logic [RAD_W-1:0]       ady, adx;
	logic [SP_W-1:0]        sidx;
	always_comb begin
		ody = first_q ? '0 : dy_q;
		odx = first_q ? '0 : dx_q;
		hs  = $signed(Y_W'(h_eff));
		ws  = $signed(Y_W'(w_eff));
		yv  = $signed(Y_W'(out_row_q)) + Y_W'(ody);
		xv  = $signed(Y_W'(out_col_q)) + Y_W'(odx);
		outside = (yv < 0) || (yv >= hs) || (xv < 0) || (xv >= ws);
		yc = (yv < 0) ? '0 : ((yv >= hs) ? hs - Y_W'(1) : yv);
		xc = (xv < 0) ? '0 : ((xv >= ws) ? ws - Y_W'(1) : xv);
		dyc = D_W'(yc - $signed(Y_W'(out_row_q)));
		slv = $signed(SL_W'(out_slot_q)) + SL_W'(dyc);
		if (slv < 0) slv = slv + SL_W'(LS_ROWS);
		else if (slv >= SL_W'(LS_ROWS)) slv = slv - SL_W'(LS_ROWS);
		rd_slot = slv[SLOT_W-1:0];
		rd_addr = ADDR_W'(rd_slot * MAX_WIDTH) + ADDR_W'(xc[COL_W-1:0]);
		wr_addr = ADDR_W'(in_slot_q * MAX_WIDTH) + ADDR_W'(in_col_q);
		ady = (ody < 0) ? RAD_W'(-ody) : RAD_W'(ody);
		adx = (odx < 0) ? RAD_W'(-odx) : RAD_W'(odx);
		sidx = SP_W'(ady) * SP_W'(ady) + SP_W'(adx) * SP_W'(adx);
	end

	// Line store: write on pixel beats, read one tap per cycle
	always_ff @(posedge clk) begin
		if (accept_in && (cmd == CMD_PIXEL) && !frame_in_q)
			line_mem[wr_addr] <= pixel;
		ls_rdata <= line_mem[rd_addr];
	end

	// Range weight table
	logic [PIX_W-1:0] p_cur, diff;
	always_comb begin
		p_cur = (brd_s1 && !bmode_q) ? bvalue_q : ls_rdata;
		diff  = (p_cur > centre_q) ? (p_cur - centre_q) : (centre_q - p_cur);
	end

	always_ff @(posedge clk) begin
		if (accept_in && (cmd == CMD_RANGE))
			range_mem[table_index] <= table_weight[WEIGHT_BITS-1:0];
		rg_rdata <= range_mem[diff];
	end

	// Spatial weight registers
	always_ff @(posedge clk) begin
		if (accept_in && (cmd == CMD_SPAT) && (32'(table_index) < SP_DEPTH))
			spatial_q[table_index[SP_W-1:0]] <= table_weight[WEIGHT_BITS-1:0];
	end

	// Weight and accumulate pipeline datapath
	always_ff @(posedge clk) begin
		ctr_s1  <= first_q;
		brd_s1  <= outside;
		sidx_s1 <= sidx;
		if (v_s1 && ctr_s1) centre_q <= p_cur;
		p_s2    <= p_cur;
		s_s2    <= spatial_q[sidx_s1];
		p_s3    <= p_s2;
		w_s3    <= W_W'(s_s2) * W_W'(rg_rdata);
		prod_s4 <= PROD_W'(w_s3) * PROD_W'(p_s3);
		wn_s4   <= w_s3;
		if (state_q == ST_CHECK) begin
			sum_q  <= '0;
			norm_q <= '0;
		end else if (v_s4) begin
			sum_q  <= sum_q + SUM_W'(prod_s4);
			norm_q <= norm_q + NORM_W'(wn_s4);
		end
		if (div_done) res_q <= div_out.zero ? div_out.centre
			: (div_out.quo[QBITS-1] ? '1 : div_out.quo[PIX_W-1:0]);
	end

	// Pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_SWEEP);
			v_s2 <= v_s1 && !ctr_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Launch the division once the sums are complete
	assign div_start = (state_q == ST_DRAIN) && !v_s1 && !v_s2 && !v_s3 && !v_s4;
	always_comb begin
		div_in.rem    = sum_q;
		div_in.dvs    = SUM_W'(norm_q) << (QBITS - 1);
		div_in.quo    = '0;
		div_in.centre = centre_q;
		div_in.zero   = (norm_q == '0);
	end

	bfw_div_chain u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.start_d(div_in),
		.done   (div_done),
		.done_d (div_out)
	);

	// Sequencer, counters and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			width_q    <= DIM_W'(1024);
			height_q   <= DIM_W'(1024);
			radius_q   <= RAD_W'(1);
			bmode_q    <= 1'b1;
			bvalue_q   <= '0;
			in_col_q   <= '0;
			in_row_q   <= '0;
			in_slot_q  <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			out_slot_q <= '0;
			frame_in_q <= 1'b0;
			first_q    <= 1'b0;
			dy_q       <= '0;
			dx_q       <= '0;
			out_valid  <= 1'b0;
			filtered   <= '0;
			last       <= 1'b0;
		end else begin
			// Drop the taken beat unless a new one replaces it below
			if (out_take && (state_q != ST_DONE)) out_valid <= 1'b0;

			// Any register write restarts the frame
			if (cfg_we) begin
				case (cfg_addr)
					REG_WIDTH:  width_q  <= cfg_wdata[DIM_W-1:0];
					REG_HEIGHT: height_q <= cfg_wdata[DIM_W-1:0];
					REG_RADIUS: radius_q <= cfg_wdata[RAD_W-1:0];
					REG_BMODE:  bmode_q  <= cfg_wdata[0];
					REG_BVALUE: bvalue_q <= cfg_wdata[PIX_W-1:0];
					default: ;
				endcase
				if (32'(cfg_addr) <= 32'(REG_BVALUE)) begin
					in_col_q   <= '0;
					in_row_q   <= '0;
					in_slot_q  <= '0;
					out_col_q  <= '0;
					out_row_q  <= '0;
					out_slot_q <= '0;
					frame_in_q <= 1'b0;
				end
			end

			case (state_q)
				ST_IDLE: begin
					if (accept_in && !cmd[1]) begin
						state_q <= ST_CHECK;
						// Advance the input position on a stored pixel
						if ((cmd == CMD_PIXEL) && !frame_in_q) begin
							if (DIM_W'(in_col_q) + DIM_W'(1) >= w_eff) begin
								in_col_q <= '0;
								if (DIM_W'(in_row_q) + DIM_W'(1) >= h_eff) begin
									in_row_q   <= '0;
									in_slot_q  <= '0;
									frame_in_q <= 1'b1;
								end else begin
									in_row_q  <= in_row_q + 1'b1;
									in_slot_q <= (32'(in_slot_q) == LS_ROWS - 1) ? '0
										: in_slot_q + 1'b1;
								end
							end else begin
								in_col_q <= in_col_q + 1'b1;
							end
						end
					end
				end
				ST_CHECK: begin
					if (ready_now) begin
						state_q <= ST_SWEEP;
						first_q <= 1'b1;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_SWEEP: begin
					// Centre tap first, then the window in raster order
					if (first_q) begin
						first_q <= 1'b0;
						dy_q    <= -$signed(D_W'(r_eff));
						dx_q    <= -$signed(D_W'(r_eff));
					end else if (dx_q == $signed(D_W'(r_eff))) begin
						dx_q <= -$signed(D_W'(r_eff));
						dy_q <= dy_q + D_W'(1);
						if (dy_q == $signed(D_W'(r_eff))) state_q <= ST_DRAIN;
					end else begin
						dx_q <= dx_q + D_W'(1);
					end
				end
				ST_DRAIN: begin
					if (div_start) state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) state_q <= ST_DONE;
				end
				ST_DONE: begin
					// Hand the result over once the output register is free
					if (!out_valid || !out_stall) begin
						out_valid <= 1'b1;
						filtered  <= res_q;
						last      <= frame_last;
						state_q   <= ST_IDLE;
						if (frame_last) begin
							in_col_q   <= '0;
							in_row_q   <= '0;
							in_slot_q  <= '0;
							out_col_q  <= '0;
							out_row_q  <= '0;
							out_slot_q <= '0;
							frame_in_q <= 1'b0;
						end else if (DIM_W'(out_col_q) + DIM_W'(1) >= w_eff) begin
							out_col_q  <= '0;
							out_row_q  <= out_row_q + 1'b1;
							out_slot_q <= (32'(out_slot_q) == LS_ROWS - 1) ? '0
								: out_slot_q + 1'b1;
						end else begin
							out_col_q <= out_col_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: design/bfw_checker.sv
// Port-level checks for the bilateral filter window, bound to the top level.
`timescale 1ns / 1ps
module bfw_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic [bfw_pkg::CMD_W-1:0]   cmd,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [bfw_pkg::PIX_W-1:0]   filtered,
	input logic                        last
);
	import bfw_pkg::*;

	// Stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(filtered) && $stable(last))
		else $error("stalled result beat changed");

	// Table loads never raise a result
	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && ((cmd == CMD_RANGE) || (cmd == CMD_SPAT)) && !out_valid
		|=> !out_valid)
		else $error("table load produced a result");

	// A pixel or flush beat occupies the block next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && ((cmd == CMD_PIXEL) || (cmd == CMD_FLUSH)) |=> in_stall)
		else $error("pixel beat did not occupy the block");

endmodule

bind bilateral_filter_window bfw_checker u_bfw_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_stall (in_stall),
	.cmd      (cmd),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.filtered (filtered),
	.last     (last)
);

FILE: bench/tb_bilateral_filter_window.sv
// Self-checking testbench for the streaming bilateral filter window block.
`timescale 1ns / 1ps
module tb_bilateral_filter_window;
	import bfw_pkg::*;

	localparam int DRAIN_CYCLES = 120;
	localparam int RANDOM_ITEMS = 30;
	localparam int HOLD_CYCLES  = 600;
	localparam int EXTREME_STOP = 16;

	typedef struct {
		logic [PIX_W-1:0] px;
		logic             lst;
	} filtered_px_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [CMD_W-1:0]    cmd;
	logic [PIX_W-1:0]    pixel;
	logic [TIDX_W-1:0]   table_index;
	logic [TW_W-1:0]     table_weight;
	logic                out_valid;
	logic                out_stall;
	logic [PIX_W-1:0]    filtered;
	logic                last;
	logic                cfg_we;
	logic [CFG_AW-1:0]   cfg_addr;
	logic [CFG_DW-1:0]   cfg_wdata;

	// Filter image state mirrored from the block
	logic [PIX_W-1:0]    line_copy [LS_ROWS*MAX_WIDTH];
	logic [TW_W-1:0]     range_tab [RG_DEPTH];
	logic [TW_W-1:0]     spat_tab [SP_DEPTH];
	int unsigned         in_row, in_col, out_row, out_col;
	bit                  frame_in;
	logic [DIM_W-1:0]    img_w, img_h;
	logic [1:0]          win_r;
	logic                bmode;
	logic [PIX_W-1:0]    bvalue;

	filtered_px_t        pending_px [$];
	int                  errors = 0;
	int                  items_sent = 0;
	bit                  tx_calm = 0;
	bit                  rx_calm = 0;
	bit                  hold_tgl = 0;
	bit                  hold_tgl_q = 0;
	int                  hold_cnt = 0;
	int                  stall_run = 0;

	bilateral_filter_window u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .pixel(pixel), .table_index(table_index), .table_weight(table_weight),
		.out_valid(out_valid), .out_stall(out_stall), .filtered(filtered), .last(last),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Clamp the configured geometry the way the block does
	function automatic int eff_w();
		if (img_w < 1) return 1;
		return (img_w > MAX_WIDTH) ? MAX_WIDTH : int'(img_w);
	endfunction

	function automatic int eff_h();
		if (img_h < 1) return 1;
		return (img_h > MAX_HEIGHT) ? MAX_HEIGHT : int'(img_h);
	endfunction

	function automatic int eff_r();
		return (win_r > MAX_RADIUS) ? MAX_RADIUS : int'(win_r);
	endfunction

	// Fetch one window tap, applying the border rule outside the image
	function automatic int tap(int y, int x);
		int w, h;
		w = eff_w();
		h = eff_h();
		if (y < 0 || y >= h || x < 0 || x >= w) begin
			if (bmode == 1'b0) return bvalue;
			if (y < 0) y = 0;
			if (y >= h) y = h - 1;
			if (x < 0) x = 0;
			if (x >= w) x = w - 1;
		end
		return line_copy[(y % LS_ROWS) * MAX_WIDTH + x];
	endfunction

	function automatic logic [PIX_W-1:0] filter_px(int row, int col);
		int r, c, p, d;
		longint unsigned sum, norm, wgt, q;
		r = eff_r();
		c = tap(row, col);
		sum = 0;
		norm = 0;
		for (int dy = -r; dy <= r; dy++) begin
			for (int dx = -r; dx <= r; dx++) begin
				p = tap(row + dy, col + dx);
				d = (p > c) ? p - c : c - p;
				wgt = longint'(spat_tab[dy*dy + dx*dx]) * longint'(range_tab[d]);
				sum += wgt * p;
				norm += wgt;
			end
		end
		if (norm == 0) return c;
		q = sum / norm;
		return (q > 255) ? 8'd255 : q[7:0];
	endfunction

	// Advance the mirrored state by one accepted beat, queueing its result
	function automatic void predict_beat(logic [CMD_W-1:0] c, logic [PIX_W-1:0] pix,
			logic [TIDX_W-1:0] idx, logic [TW_W-1:0] wt);
		int w, h, r, nr, nc;
		bit ready, lst;
		filtered_px_t res;
		w = eff_w();
		h = eff_h();
		r = eff_r();
		if (c == CMD_RANGE) begin
			range_tab[idx] = wt;
			return;
		end
		if (c == CMD_SPAT) begin
			if (idx < SP_DEPTH) spat_tab[idx] = wt;
			return;
		end
		if (c == CMD_PIXEL && !frame_in) begin
			line_copy[(in_row % LS_ROWS) * MAX_WIDTH + in_col] = pix;
			in_col++;
			if (in_col >= w) begin
				in_col = 0;
				in_row++;
				if (in_row >= h) begin
					in_row = 0;
					frame_in = 1;
				end
			end
		end
		nr = (out_row + r < h - 1) ? out_row + r : h - 1;
		nc = (out_col + r < w - 1) ? out_col + r : w - 1;
		ready = frame_in || in_row > nr || (in_row == nr && in_col > nc);
		if (!ready) return;
		lst = (out_row == h - 1) && (out_col == w - 1);
		res.px = filter_px(out_row, out_col);
		res.lst = lst;
		pending_px.push_back(res);
		if (lst) begin
			in_row = 0; in_col = 0; out_row = 0; out_col = 0; frame_in = 0;
		end else begin
			out_col++;
			if (out_col >= w) begin
				out_col = 0;
				out_row++;
			end
		end
	endfunction

	task automatic report_mismatch(string what, int want, int got);
		$display("ERROR at %0t: %s expected %0d got %0d", $time, what, want, got);
		errors++;
	endtask

	// Send one beat: optional gap, then hold until accepted
	task automatic send_beat(logic [CMD_W-1:0] c, logic [PIX_W-1:0] pix,
			logic [TIDX_W-1:0] idx, logic [TW_W-1:0] wt);
		int gap, pick;
		gap = 0;
		if (!tx_calm) begin
			pick = $urandom_range(0, 99);
			if (pick >= 95) gap = $urandom_range(10, 40);
			else if (pick >= 65) gap = $urandom_range(1, 3);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		pixel <= pix;
		table_index <= idx;
		table_weight <= wt;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_beat(c, pix, idx, wt);
		items_sent++;
	endtask

	// Drop valid, wait for every result, then let trailing work settle
	task automatic wait_drain();
		in_valid <= 1'b0;
		while (pending_px.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic put_reg(logic [CFG_AW-1:0] a, logic [CFG_DW-1:0] v);
		cfg_we <= 1'b1;
		cfg_addr <= a;
		cfg_wdata <= v;
		@(posedge clk);
		case (a)
			REG_WIDTH:  img_w = v;
			REG_HEIGHT: img_h = v;
			REG_RADIUS: win_r = v[1:0];
			REG_BMODE:  bmode = v[0];
			REG_BVALUE: bvalue = v[7:0];
			default: ;
		endcase
	endtask

	// Write every register while idle; each write restarts the frame
	task automatic set_frame(int w, int h, int r, int m, int bv);
		wait_drain();
		put_reg(REG_WIDTH, w);
		put_reg(REG_HEIGHT, h);
		put_reg(REG_RADIUS, r);
		put_reg(REG_BMODE, m);
		put_reg(REG_BVALUE, bv);
		cfg_we <= 1'b0;
		in_row = 0; in_col = 0; out_row = 0; out_col = 0; frame_in = 0;
	endtask

	function automatic logic [TW_W-1:0] rand_weight();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 8) return '0;
		if (pick < 16) return '1;
		return $urandom_range(0, 65535);
	endfunction

	function automatic logic [PIX_W-1:0] make_pixel(int kind, int n);
		case (kind)
			1: return (n % 2) ? 8'd255 : 8'd0;
			2: return 8'd100 + $urandom_range(0, 6);
			3: return ($urandom_range(0, 1)) ? $urandom_range(0, 3) : $urandom_range(252, 255);
			default: return $urandom_range(0, 255);
		endcase
	endfunction

	// Flush ticks, stray table reloads and spatial loads, some of them out of range
	task automatic send_noise();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			send_beat(CMD_FLUSH, $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 65535));
		else if (pick < 85)
			send_beat(CMD_RANGE, 0, $urandom_range(0, 255), rand_weight());
		else
			send_beat(CMD_SPAT, 0, $urandom_range(0, 31), rand_weight());
	endtask

	// Stream one frame; stop early to leave a broken frame behind
	task automatic run_frame(int kind, int noise, int stop_at);
		int n, total;
		total = eff_w() * eff_h();
		n = 0;
		while (n < total && n != stop_at) begin
			if (noise > 0 && $urandom_range(0, 99) < noise) begin
				send_noise();
			end else begin
				send_beat(CMD_PIXEL, make_pixel(kind, n), $urandom_range(0, 255),
					$urandom_range(0, 65535));
				n++;
			end
		end
		if (n != total) return;
		// drain the tail; a pixel now is discarded and acts as a flush
		while (frame_in) begin
			if ($urandom_range(0, 99) < 10)
				send_beat(CMD_PIXEL, $urandom_range(0, 255), 0, 0);
			else
				send_beat(CMD_FLUSH, 0, 0, 0);
		end
	endtask

	task automatic test_load_tables();
		for (int i = 0; i < RG_DEPTH; i++) send_beat(CMD_RANGE, 0, i, rand_weight());
		for (int i = 0; i < SP_DEPTH; i++) send_beat(CMD_SPAT, 0, i, rand_weight());
		// indexes past the spatial table are ignored
		send_beat(CMD_SPAT, 0, SP_DEPTH, 16'hFFFF);
		send_beat(CMD_SPAT, 0, 8'hFF, 16'hFFFF);
		send_beat(CMD_SPAT, 0, 0, 16'hFFFF);
	endtask

	task automatic test_directed_frames();
		send_beat(CMD_FLUSH, 0, 0, 0);
		set_frame(5, 4, 1, 1, 0);
		run_frame(1, 0, -1);
		set_frame(6, 3, 0, 0, 255);
		run_frame(3, 0, -1);
		set_frame(4, 5, 3, 0, 0);
		run_frame(0, 15, -1);
		set_frame(7, 3, 2, 1, 128);
		run_frame(2, 0, -1);
	endtask

	// Zero spatial weights give a zero total, so the centre passes through
	task automatic test_zero_weight();
		wait_drain();
		for (int i = 0; i < SP_DEPTH; i++) send_beat(CMD_SPAT, 0, i, 0);
		set_frame(4, 3, 1, 0, 77);
		run_frame(0, 0, -1);
		for (int i = 0; i < SP_DEPTH; i++) send_beat(CMD_SPAT, 0, i, rand_weight());
	endtask

	task automatic test_extremes();
		set_frame(2047, 1, 3, 0, 200);
		run_frame(0, 0, EXTREME_STOP);
		set_frame(0, 2047, 3, 1, 0);
		run_frame(3, 0, EXTREME_STOP);
		set_frame(0, 0, 0, 0, 0);
		run_frame(0, 0, -1);
		set_frame(1024, 2, 3, 1, 255);
		run_frame(1, 0, EXTREME_STOP);
	endtask

	task automatic test_output_backpressure();
		set_frame(8, 6, 1, 1, 0);
		tx_calm = 1;
		hold_tgl = !hold_tgl;
		run_frame(0, 0, -1);
		tx_calm = 0;
	endtask

	task automatic test_random_frames();
		int goal, w, h, total, stop_at;
		goal = items_sent + RANDOM_ITEMS;
		while (items_sent < goal) begin
			w = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 12) : $urandom_range(13, 64);
			h = $urandom_range(1, 8);
			set_frame(w, h, $urandom_range(0, 3), $urandom_range(0, 1), $urandom_range(0, 255));
			total = w * h;
			stop_at = ($urandom_range(0, 99) < 10) ? $urandom_range(0, total - 1) : -1;
			rx_calm = ($urandom_range(0, 99) < 20);
			tx_calm = ($urandom_range(0, 99) < 20);
			run_frame($urandom_range(0, 3), 10, stop_at);
		end
		rx_calm = 0;
		tx_calm = 0;
	endtask

	// Result side: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		int pick;
		if (hold_tgl != hold_tgl_q) begin
			hold_tgl_q <= hold_tgl;
			out_stall <= 1'b1;
			hold_cnt <= HOLD_CYCLES;
		end else if (hold_cnt > 0) begin
			out_stall <= 1'b1;
			hold_cnt <= hold_cnt - 1;
		end else if (stall_run > 0) begin
			out_stall <= 1'b1;
			stall_run <= stall_run - 1;
		end else if (rx_calm) begin
			out_stall <= 1'b0;
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				out_stall <= 1'b0;
			end else if (pick < 96) begin
				out_stall <= 1'b1;
				stall_run <= $urandom_range(0, 2);
			end else begin
				out_stall <= 1'b1;
				stall_run <= $urandom_range(10, 40);
			end
		end
	end

	// Compare each result beat with the oldest expectation
	always @(posedge clk) begin : check_results
		filtered_px_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_px.size() == 0) begin
				report_mismatch("unexpected result, filtered", -1, filtered);
			end else begin
				want = pending_px.pop_front();
				if (filtered !== want.px) report_mismatch("filtered", want.px, filtered);
				if (last !== want.lst) report_mismatch("last", want.lst, last);
			end
		end
	end

	initial begin
		#20_000_000;
		$display("bilateral_filter_window: mismatch");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		cmd = CMD_PIXEL;
		pixel = '0;
		table_index = '0;
		table_weight = '0;
		cfg_we = 1'b0;
		cfg_addr = REG_WIDTH;
		cfg_wdata = '0;
		img_w = 11'd1024;
		img_h = 11'd1024;
		win_r = 2'd1;
		bmode = 1'b1;
		bvalue = '0;
		in_row = 0; in_col = 0; out_row = 0; out_col = 0; frame_in = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_load_tables();
		test_directed_frames();
		test_zero_weight();
		test_extremes();
		test_output_backpressure();
		test_random_frames();
		wait_drain();
		if (errors == 0)
			$display("bilateral_filter_window: match");
		else
			$display("bilateral_filter_window: mismatch");
		$finish;
	end

endmodule

FILE: bilateral_filter_window.f
design/bfw_pkg.sv
design/bfw_div_cell.sv
design/bfw_div_chain.sv
design/bilateral_filter_window.sv
design/bfw_checker.sv
bench/tb_bilateral_filter_window.sv
